[rtl/core/b64f_pkg.sv]
// ----------------------------------------------------------------------------
// b64f_pkg
// Shared constants, job type and helper functions of the base64 packet framer.
// ----------------------------------------------------------------------------
package b64f_pkg;

	localparam int BUFFER_BYTES = 4096;

	// A frame fits when 7 + 4*ceil(len/3) <= BUFFER_BYTES, i.e. len <= 3*floor((B-7)/4)
	localparam int MAX_LEN_INT = 3 * ((BUFFER_BYTES - 7) / 4);
	localparam logic [17:0] MAX_LEN = 18'(MAX_LEN_INT);

	localparam int JOB_CHARS = 11;

	localparam logic [7:0] CHAR_STX = 8'h02;
	localparam logic [7:0] CHAR_ETX = 8'h03;
	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [7:0] CRC_POLY = 8'h07;

	// Characters one request produces, oldest in entry 0
	typedef struct packed {
		logic [JOB_CHARS-1:0][7:0] chars;
		logic [3:0]                cnt;
		logic                      etx;
		logic                      err;
	} job_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] w;
		logic [7:0] r;
		w = {2'b00, v};
		if (v < 6'd26) begin
			r = w + 8'h41;
		end else if (v < 6'd52) begin
			r = w + 8'd71;
		end else if (v < 6'd62) begin
			r = w - 8'd4;
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

[rtl/core/b64f_front.sv]
// ----------------------------------------------------------------------------
// b64f_front
// Takes payload requests, tracks frame state and builds the character job.
// ----------------------------------------------------------------------------
module b64f_front
	import b64f_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_type,
	input  logic [11:0] payload_length,
	input  logic [7:0]  payload_byte,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job
);

	logic [11:0] bytes_left_q;
	logic [15:0] group_q;
	logic [1:0]  fill_q;
	logic [7:0]  crc_q;
	logic        dropping_q;

	logic [11:0] bytes_left_d;
	logic [15:0] group_d;
	logic [1:0]  fill_d;
	logic [7:0]  crc_d;
	logic        dropping_d;
	job_t        job;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (job.cnt != 4'd0);
	assign push_job = job;

	always_comb begin
		logic        start;
		logic        over;
		logic        take;
		logic        full;
		logic        fin;
		logic [15:0] e_group;
		logic [1:0]  e_fill;
		logic [7:0]  e_crc;
		logic [15:0] n_group;
		logic [1:0]  n_fill;
		logic [7:0]  n_crc;
		logic [6:0][7:0] fc;
		logic [3:0]  fcnt;
		logic        base4;
		logic [23:0] v;

		start   = (bytes_left_q == 12'd0);
		over    = start && ({6'd0, payload_length} > MAX_LEN);
		e_group = start ? 16'd0 : group_q;
		e_fill  = start ? 2'd0 : fill_q;
		e_crc   = start ? 8'd0 : crc_q;
		take    = start ? (!over && payload_length != 12'd0) : !dropping_q;
		full    = take && (e_fill == 2'd2);
		v       = {e_group, payload_byte};

		n_crc   = take ? crc8_byte(e_crc, payload_byte) : e_crc;
		n_fill  = take ? (full ? 2'd0 : e_fill + 2'd1) : e_fill;
		n_group = take ? (full ? 16'd0 : {e_group[7:0], payload_byte}) : e_group;
		fin     = start ? (!over && payload_length <= 12'd1)
		                : (!dropping_q && bytes_left_q == 12'd1);

		// tail of the frame: padded group, CRC pair, ETX
		fc = '0;
		if (n_fill == 2'd1) begin
			fc[0] = b64_char(n_group[7:2]);
			fc[1] = b64_char({n_group[1:0], 4'b0000});
			fc[2] = CHAR_PAD;
			fc[3] = CHAR_PAD;
			fc[4] = b64_char(n_crc[7:2]);
			fc[5] = b64_char({n_crc[1:0], 4'b0000});
			fc[6] = CHAR_ETX;
			fcnt  = 4'd7;
		end else if (n_fill == 2'd2) begin
			fc[0] = b64_char(n_group[15:10]);
			fc[1] = b64_char(n_group[9:4]);
			fc[2] = b64_char({n_group[3:0], 2'b00});
			fc[3] = CHAR_PAD;
			fc[4] = b64_char(n_crc[7:2]);
			fc[5] = b64_char({n_crc[1:0], 4'b0000});
			fc[6] = CHAR_ETX;
			fcnt  = 4'd7;
		end else begin
			fc[0] = b64_char(n_crc[7:2]);
			fc[1] = b64_char({n_crc[1:0], 4'b0000});
			fc[2] = CHAR_ETX;
			fcnt  = 4'd3;
		end

		job   = '0;
		base4 = start || full;
		if (over) begin
			job.chars[0] = 8'h00;
			job.cnt      = 4'd1;
			job.err      = 1'b1;
		end else begin
			if (start) begin
				job.chars[0] = CHAR_STX;
				job.chars[1] = frame_type;
				job.chars[2] = b64_char(payload_length[11:6]);
				job.chars[3] = b64_char(payload_length[5:0]);
			end else if (full) begin
				job.chars[0] = b64_char(v[23:18]);
				job.chars[1] = b64_char(v[17:12]);
				job.chars[2] = b64_char(v[11:6]);
				job.chars[3] = b64_char(v[5:0]);
			end
			if (fin) begin
				for (int k = 0; k < 7; k++) begin
					if (base4) begin
						job.chars[k+4] = fc[k];
					end else begin
						job.chars[k] = fc[k];
					end
				end
			end
			job.cnt = (base4 ? 4'd4 : 4'd0) + (fin ? fcnt : 4'd0);
			job.etx = fin;
		end

		// next state
		if (start) begin
			bytes_left_d = (payload_length != 12'd0) ? payload_length - 12'd1 : 12'd0;
			dropping_d   = over && (payload_length > 12'd1);
		end else begin
			bytes_left_d = bytes_left_q - 12'd1;
			dropping_d   = dropping_q && (bytes_left_q != 12'd1);
		end
		if (fin) begin
			group_d = 16'd0;
			fill_d  = 2'd0;
			crc_d   = 8'd0;
		end else begin
			group_d = n_group;
			fill_d  = n_fill;
			crc_d   = n_crc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			group_q      <= '0;
			fill_q       <= '0;
			crc_q        <= '0;
			dropping_q   <= 1'b0;
		end else if (accept) begin
			bytes_left_q <= bytes_left_d;
			group_q      <= group_d;
			fill_q       <= fill_d;
			crc_q        <= crc_d;
			dropping_q   <= dropping_d;
		end
	end

endmodule

[rtl/core/b64f_queue.sv]
// ----------------------------------------------------------------------------
// b64f_queue
// Two-entry job queue between the front and the character sequencer.
// ----------------------------------------------------------------------------
module b64f_queue
	import b64f_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/b64f_back.sv]
// ----------------------------------------------------------------------------
// b64f_back
// Character sequencer: shifts out one character of the current job per request.
// ----------------------------------------------------------------------------
module b64f_back
	import b64f_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       frame_end,
	output logic       oversize_error
);

	job_t cur_q;
	logic cur_valid_q;
	logic last;
	logic load;

	assign last           = (cur_q.cnt == 4'd1);
	assign load           = !cur_valid_q || (out_ready && last);
	assign pop            = load && !q_empty;

	assign out_valid      = cur_valid_q;
	assign out_char       = cur_q.chars[0];
	assign last_of_run    = last;
	assign frame_end      = cur_q.etx && last;
	assign oversize_error = cur_q.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (load) begin
			cur_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_job;
		end else if (cur_valid_q && out_ready && !last) begin
			cur_q.chars <= cur_q.chars >> 8;
			cur_q.cnt   <= cur_q.cnt - 4'd1;
		end
	end

endmodule

[rtl/core/base64_crc8_packet_framer.sv]
// ----------------------------------------------------------------------------
// base64_crc8_packet_framer
// Frames payload bytes as STX, type, base64 length, base64 payload, CRC-8, ETX.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one payload byte per request; the first
// request of a frame also carries frame_type and payload_length. An empty
// frame is one request whose byte is ignored. Output channel
// (out_valid/out_ready): one serial character per request, last_of_run on the
// final character caused by an input request, frame_end on ETX, and a single
// oversize_error character for a frame too large for the buffer, whose
// remaining bytes are then consumed silently.
// The first character is registered in the job queue and then in the sequencer
// before out_valid rises. The output sequencer emits one character per cycle
// while out_ready is high, so an input request occupies the output for each
// character it causes (0 to 11, about 4/3 per byte on average). Requests that
// cause no character push no job. A two-entry job queue lets the front keep
// taking bytes while the sequencer drains; in_ready drops only when it is full.
// When the receiver stalls, the current character holds and the queue fills.
// Reset clears frame state, the queue and the output; no clearing pass.
// ----------------------------------------------------------------------------
module base64_crc8_packet_framer
	import b64f_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_type,
	input  logic [11:0] payload_length,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last_of_run,
	output logic        frame_end,
	output logic        oversize_error
);

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t pop_job;

	b64f_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.frame_type     (frame_type),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.q_full         (q_full),
		.push           (push),
		.push_job       (push_job)
	);

	b64f_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	b64f_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_job          (pop_job),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_char       (out_char),
		.last_of_run    (last_of_run),
		.frame_end      (frame_end),
		.oversize_error (oversize_error)
	);

endmodule
